[rtl/alignment_column_consensus_macros.svh]
// Assertion helpers used by the consensus RTL file.
`ifndef ALIGNMENT_COLUMN_CONSENSUS_MACROS_SVH
`define ALIGNMENT_COLUMN_CONSENSUS_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define ACC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/acc_pkg.sv]
`timescale 1ns / 1ps

package acc_pkg;

	// Row counters stop at this value
	localparam int MAX_ROWS = 1024;
	localparam int CNT_W    = $clog2(MAX_ROWS + 1);
	localparam int NUM_BASES = 4;
	localparam int GOOD_W   = 32;

	// ASCII codes
	localparam logic [7:0] CH_A   = 8'h41;
	localparam logic [7:0] CH_T   = 8'h54;
	localparam logic [7:0] CH_G   = 8'h47;
	localparam logic [7:0] CH_C   = 8'h43;
	localparam logic [7:0] CH_N   = 8'h4E;
	localparam logic [7:0] CH_GAP = 8'h2D;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LT  = 8'h74;
	localparam logic [7:0] CH_LG  = 8'h67;
	localparam logic [7:0] CH_LC  = 8'h63;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [2:0] {
		BASE_A    = 3'd0,
		BASE_T    = 3'd1,
		BASE_G    = 3'd2,
		BASE_C    = 3'd3,
		BASE_NONE = 3'd4
	} base_code_t;

	typedef struct packed {
		logic [7:0] letter;
		logic       last_row;
		logic       range_start;
		logic       last_column;
	} item_t;

	typedef struct packed {
		logic [6:0]        consensus_letter;
		logic              column_good;
		logic [GOOD_W-1:0] good_columns;
		logic              range_complete;
	} result_t;

	// Either case of A, T, G, C maps to its counter; all else is ignored
	function automatic base_code_t base_code(input logic [7:0] b);
		base_code_t c;
		case (b)
			CH_A, CH_LA: c = BASE_A;
			CH_T, CH_LT: c = BASE_T;
			CH_G, CH_LG: c = BASE_G;
			CH_C, CH_LC: c = BASE_C;
			default:     c = BASE_NONE;
		endcase
		return c;
	endfunction

	// Counter index back to its upper case letter
	function automatic logic [7:0] base_ascii(input logic [1:0] k);
		logic [7:0] a;
		case (k)
			2'd0:    a = CH_A;
			2'd1:    a = CH_T;
			2'd2:    a = CH_G;
			default: a = CH_C;
		endcase
		return a;
	endfunction

endpackage

[rtl/alignment_column_consensus.sv]
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// item     | in        | item_valid/stall    | letter, last_row, range_start, last_column
// result   | out       | result_valid/stall  | consensus_letter, column_good, good_columns,
//          |           |                     | range_complete
//
// One item per cycle while item_stall is low. An accepted item is held in the input
// register; the column state update and the majority vote both work on it there, and
// the result register takes the result when a last row item leaves the input register.
// arst_n clears all column state; the next item opens a new column.
// A stalled result holds the result register; the input register keeps draining
// rows that end no column and item_stall rises only when a last row is blocked.

`include "alignment_column_consensus_macros.svh"

module alignment_column_consensus
	import acc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	// Input register
	logic  valid_s1;
	item_t item_s1;

	// Column state
	cnt_t              cnt_q [NUM_BASES];
	logic [7:0]        first_q;
	logic              all_eq_q;
	logic              open_q;
	logic              restart_q;
	logic [GOOD_W-1:0] good_cnt_q;

	// Result register
	logic    res_valid_q;
	result_t res_q;

	// Stage 1 advance: blocked only when a result must go out and cannot
	logic s1_adv;
	logic s1_fire;
	assign s1_adv     = !(valid_s1 && item_s1.last_row && res_valid_q && result_stall);
	assign s1_fire    = valid_s1 && s1_adv;
	assign item_stall = valid_s1 && !s1_adv;

	// Next column state for the item in stage 1
	base_code_t        code;
	cnt_t              cnt_nx [NUM_BASES];
	logic [7:0]        first_nx;
	logic              all_eq_nx;
	logic              restart_nx;
	logic              good;
	logic [GOOD_W-1:0] good_base;
	logic [GOOD_W-1:0] good_nx;
	cnt_t              best_cnt;
	logic [7:0]        best_letter;

	always_comb begin
		code = base_code(item_s1.letter);
		for (int k = 0; k < NUM_BASES; k++) begin
			cnt_nx[k] = open_q ? cnt_q[k] : '0;
			if (code == base_code_t'(k) && cnt_nx[k] < CNT_W'(MAX_ROWS)) begin
				cnt_nx[k] = cnt_nx[k] + 1'b1;
			end
		end
		first_nx   = open_q ? first_q : item_s1.letter;
		all_eq_nx  = open_q ? (all_eq_q && (item_s1.letter == first_q)) : 1'b1;
		restart_nx = open_q ? restart_q : item_s1.range_start;
	end

	// Majority vote, earlier base wins ties
	always_comb begin
		best_cnt    = '0;
		best_letter = CH_N;
		for (int k = 0; k < NUM_BASES; k++) begin
			if (cnt_nx[k] > best_cnt) begin
				best_cnt    = cnt_nx[k];
				best_letter = base_ascii(2'(k));
			end
		end
	end

	// Good flag and saturating good column count
	always_comb begin
		good      = all_eq_nx && (first_nx != CH_GAP) && (first_nx != CH_N);
		good_base = restart_nx ? '0 : good_cnt_q;
		good_nx   = good_base;
		if (good && (good_base != '1)) begin
			good_nx = good_base + 1'b1;
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Column state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_BASES; k++) begin
				cnt_q[k] <= '0;
			end
			first_q    <= '0;
			all_eq_q   <= 1'b1;
			open_q     <= 1'b0;
			restart_q  <= 1'b0;
			good_cnt_q <= '0;
		end else if (s1_fire) begin
			cnt_q     <= cnt_nx;
			first_q   <= first_nx;
			all_eq_q  <= all_eq_nx;
			open_q    <= !item_s1.last_row;
			restart_q <= item_s1.last_row ? 1'b0 : restart_nx;
			if (item_s1.last_row) begin
				good_cnt_q <= good_nx;
			end
		end
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_fire && item_s1.last_row) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_fire && item_s1.last_row) begin
			res_q.consensus_letter <= best_letter[6:0];
			res_q.column_good      <= good;
			res_q.good_columns     <= good_nx;
			res_q.range_complete   <= item_s1.last_column;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Checks
	`ACC_ASSERT_NOW(a_letter_legal, result_valid,
		(result.consensus_letter == CH_A[6:0]) || (result.consensus_letter == CH_T[6:0]) ||
		(result.consensus_letter == CH_G[6:0]) || (result.consensus_letter == CH_C[6:0]) ||
		(result.consensus_letter == CH_N[6:0]), "consensus letter out of set")
	`ACC_ASSERT_NOW(a_good_counted, result_valid && result.column_good,
		result.good_columns != '0, "good column not counted")
	`ACC_ASSERT_NOW(a_cnt_sat, 1'b1,
		(cnt_q[0] <= CNT_W'(MAX_ROWS)) && (cnt_q[1] <= CNT_W'(MAX_ROWS)) &&
		(cnt_q[2] <= CNT_W'(MAX_ROWS)) && (cnt_q[3] <= CNT_W'(MAX_ROWS)),
		"base counter past saturation")
	`ACC_ASSERT_NEXT(a_last_row_closes, s1_fire && item_s1.last_row,
		!open_q && result_valid, "last row did not close column")

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import acc_pkg::*;

	localparam logic [7:0] BASE_LETTER [4] = '{CH_A, CH_T, CH_G, CH_C};

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	alignment_column_consensus dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #4 clk = ~clk;

	// Predicted column state
	cnt_t        lane_count [4];
	logic [7:0]  col_first;
	logic        col_uniform;
	logic        col_open;
	logic        col_restart;
	logic [31:0] good_run;

	result_t consensus_due [$];
	int      errors = 0;

	// Sender and receiver pacing
	int gap_max     = 0;
	int burst_left  = 0;
	int stall_pct   = 0;
	int stall_run   = 0;
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;

	// Fold one accepted letter into the column, queue the result on the last row
	task automatic tally_letter(input item_t it);
		int          lane;
		int          best;
		cnt_t        best_n;
		logic        good;
		result_t     r;
		if (!col_open) begin
			for (int k = 0; k < NUM_BASES; k++) lane_count[k] = '0;
			col_first   = it.letter;
			col_uniform = 1'b1;
			col_restart = it.range_start;
			col_open    = 1'b1;
		end else if (it.letter != col_first) begin
			col_uniform = 1'b0;
		end
		case (it.letter)
			CH_A, CH_LA: lane = 0;
			CH_T, CH_LT: lane = 1;
			CH_G, CH_LG: lane = 2;
			CH_C, CH_LC: lane = 3;
			default:     lane = -1;
		endcase
		if (lane >= 0 && lane_count[lane] < MAX_ROWS)
			lane_count[lane] = lane_count[lane] + 1'b1;
		if (it.last_row) begin
			best   = -1;
			best_n = '0;
			// strict compare keeps the earlier base on a tie
			for (int k = 0; k < NUM_BASES; k++) begin
				if (lane_count[k] > best_n) begin
					best_n = lane_count[k];
					best   = k;
				end
			end
			good = col_uniform && col_first != CH_GAP && col_first != CH_N;
			if (col_restart) good_run = '0;
			if (good && good_run != '1) good_run = good_run + 1;
			r.consensus_letter = (best >= 0) ? BASE_LETTER[best][6:0] : CH_N[6:0];
			r.column_good      = good;
			r.good_columns     = good_run;
			r.range_complete   = it.last_column;
			consensus_due = {consensus_due, r};
			col_open    = 1'b0;
			col_restart = 1'b0;
		end
	endtask

	// Offer one item, wait for acceptance, then maybe pause between bursts
	task automatic send_item(input item_t it);
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		tally_letter(it);
		if (gap_max != 0) begin
			if (burst_left == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(posedge clk);
				burst_left = $urandom_range(0, 16);
			end else begin
				burst_left--;
			end
		end
	endtask

	// One column; range_start on other rows and last_column on non-last rows are noise
	task automatic send_column(input logic [7:0] rows [$], input logic rs_first,
			input logic rs_rest, input logic lc);
		item_t it;
		for (int r = 0; r < rows.size(); r++) begin
			it.letter      = rows[r];
			it.last_row    = (r == rows.size() - 1);
			it.range_start = (r == 0) ? rs_first : rs_rest;
			it.last_column = (r == rows.size() - 1) ? lc : !lc;
			send_item(it);
		end
	endtask

	// Drop valid and wait until every predicted result has come back
	task automatic settle();
		item_valid <= 1'b0;
		while (consensus_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic [7:0] any_base();
		logic [7:0] b;
		case ($urandom_range(0, 7))
			0: b = CH_A;
			1: b = CH_T;
			2: b = CH_G;
			3: b = CH_C;
			4: b = CH_LA;
			5: b = CH_LT;
			6: b = CH_LG;
			default: b = CH_LC;
		endcase
		return b;
	endfunction

	// Extremes of the byte, each base in both cases, gap, N vs n, ties, restarts
	task automatic test_directed();
		gap_max   = 3;
		stall_pct = 30;
		send_column('{CH_A}, 1'b1, 1'b0, 1'b1);
		send_column('{8'h00}, 1'b0, 1'b0, 1'b0);
		send_column('{8'hFF}, 1'b0, 1'b0, 1'b1);
		send_column('{CH_GAP}, 1'b0, 1'b0, 1'b0);
		send_column('{CH_N}, 1'b0, 1'b0, 1'b0);
		send_column('{8'h6E, 8'h6E}, 1'b0, 1'b0, 1'b0);
		// range_start off the first letter does nothing
		send_column('{CH_LA, CH_A}, 1'b0, 1'b1, 1'b1);
		send_column('{CH_LT, CH_G}, 1'b0, 1'b0, 1'b0);
		send_column('{CH_C, CH_LG, CH_G, CH_LC, CH_LC}, 1'b0, 1'b0, 1'b1);
		send_column('{8'h80, 8'h80}, 1'b1, 1'b0, 1'b0);
		// A with bit 7 set is not a base
		send_column('{8'hC1, CH_T}, 1'b0, 1'b0, 1'b0);
		settle();
	endtask

	// A runs past the row limit in both cases and stops there; a single T row follows
	task automatic test_row_saturation();
		logic [7:0] rows [$];
		gap_max   = 0;
		stall_pct = 0;
		for (int r = 0; r < MAX_ROWS + 2; r++) rows = {rows, (r[0] ? CH_LA : CH_A)};
		rows = {rows, CH_T};
		send_column(rows, 1'b1, 1'b0, 1'b1);
		settle();
	endtask

	// Receiver holds off for a long stretch while short columns keep coming
	task automatic test_backpressure();
		logic [7:0] rows [$];
		gap_max   = 0;
		stall_pct = 0;
		hold_asked++;
		@(posedge clk);
		for (int c = 0; c < 60; c++) begin
			rows = {};
			repeat ($urandom_range(1, 3)) rows = {rows, any_base()};
			send_column(rows, $urandom_range(0, 4) == 0, 1'b0, 1'($urandom_range(0, 1)));
		end
		settle();
	endtask

	// Random columns, mostly short, with pacing changed every phase
	task automatic test_random();
		logic [7:0] rows [$];
		logic [7:0] lead;
		int         sent;
		int         n;
		int         kind;
		int         phase;
		sent  = 0;
		phase = 0;
		while (sent < 200) begin
			if (sent >= phase * 50) begin
				case (phase % 4)
					0: begin gap_max = 0; stall_pct = 0;  end
					1: begin gap_max = 4; stall_pct = 25; end
					2: begin gap_max = 0; stall_pct = 50; end
					default: begin gap_max = 8; stall_pct = 10; end
				endcase
				phase++;
			end
			n = $urandom_range(0, 99);
			n = (n < 80) ? $urandom_range(1, 6) : (n < 98) ? $urandom_range(7, 30)
				: $urandom_range(31, 120);
			kind = $urandom_range(0, 99);
			case ($urandom_range(0, 9))
				0: lead = CH_GAP;
				1: lead = CH_N;
				2: lead = 8'h6E;
				3: lead = 8'($urandom_range(0, 255));
				default: lead = any_base();
			endcase
			rows = {};
			for (int r = 0; r < n; r++) begin
				if (kind < 30)
					rows = {rows, lead};
				else if (kind < 55)
					rows = {rows, (($urandom_range(0, 99) < 85) ? lead : any_base())};
				else if (kind < 85)
					rows = {rows, (($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
						: any_base())};
				else
					rows = {rows, 8'($urandom_range(0, 255))};
			end
			send_column(rows, $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			sent += n;
		end
		settle();
	endtask

	// Receiver stall pattern: long hold on request, else short random runs
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served  = hold_asked;
			hold_left    = 300;
			result_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_run > 0) begin
			stall_run--;
			result_stall <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_run    = $urandom_range(0, 3);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (consensus_due.size() == 0) begin
				errors++;
				$display("%0t unexpected result: expected none, actual %p", $time, result);
			end else begin
				want = consensus_due.pop_front();
				if (result.consensus_letter !== want.consensus_letter) begin
					errors++;
					$display("%0t consensus_letter: expected %h, actual %h", $time,
						want.consensus_letter, result.consensus_letter);
				end
				if (result.column_good !== want.column_good) begin
					errors++;
					$display("%0t column_good: expected %b, actual %b", $time,
						want.column_good, result.column_good);
				end
				if (result.good_columns !== want.good_columns) begin
					errors++;
					$display("%0t good_columns: expected %0d, actual %0d", $time,
						want.good_columns, result.good_columns);
				end
				if (result.range_complete !== want.range_complete) begin
					errors++;
					$display("%0t range_complete: expected %b, actual %b", $time,
						want.range_complete, result.range_complete);
				end
			end
		end
	end

	initial begin
		for (int k = 0; k < NUM_BASES; k++) lane_count[k] = '0;
		col_first   = '0;
		col_uniform = 1'b1;
		col_open    = 1'b0;
		col_restart = 1'b0;
		good_run    = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_row_saturation();
		test_backpressure();
		test_random();
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/acc_pkg.sv
rtl/alignment_column_consensus.sv
test/tb.sv
